// ===== design/upre_pkg.sv =====
// Shared constants, types and helpers of the UTF-8 printable run extractor.
package upre_pkg;

	// Largest effective minimum run length, in characters.
	localparam int MAX_MIN_LENGTH = 8;
	// Held bytes of a run: at most MAX_MIN_LENGTH characters of four bytes each.
	localparam int RUN_DEPTH = MAX_MIN_LENGTH * 4;
	localparam int BUF_AW = $clog2(RUN_DEPTH);
	localparam int BUF_CW = $clog2(RUN_DEPTH + 1);
	// Character counter saturates at the minimum plus one.
	localparam int CHAR_W = $clog2(MAX_MIN_LENGTH + 2);
	// Width of the min_length register.
	localparam int MINLEN_W = 4;
	localparam logic [MINLEN_W-1:0] MINLEN_RESET = 4'd4;

	// Command queue between the byte classifier and the run engine.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] NEWLINE = 8'h0A;

	// Work for the run engine, at most one per classified input word.
	typedef enum logic [1:0] {
		CMD_CHAR,
		CMD_END,
		CMD_EOS
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t       kind;
		logic            restart;
		logic [1:0]      len_m1;
		logic [3:0][7:0] bytes;
	} cmd_t;

	// Run engine states.
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_WRITE,
		BK_DECIDE,
		BK_NL,
		BK_FLUSH
	} back_state_t;

	// Minimum run length as applied: zero acts as one, large values clamp.
	function automatic logic [CHAR_W-1:0] effective_min(input logic [MINLEN_W-1:0] value);
		logic [CHAR_W-1:0] result;
		if (value == '0) begin
			result = CHAR_W'(1);
		end else if (32'(value) > MAX_MIN_LENGTH) begin
			result = CHAR_W'(MAX_MIN_LENGTH);
		end else begin
			result = CHAR_W'(value);
		end
		return result;
	endfunction

endpackage

// ===== design/utf8_printable_run_extractor_core.sv =====
// Top level of the UTF-8 printable run extractor.
// Bytes enter one per cycle into a classifier that tracks UTF-8 sequences and posts one
// command per character, rejected byte or end of stream into a four-word queue; input
// stalls only while that queue is full. The run engine behind it starts a command,
// writes each byte of a character into the 32-byte run buffer, makes a decision,
// sends an owed newline, and sends the held bytes in order when a run qualifies or
// passes through.
// The output has its own register. While a word waits there, the engine starts no new
// command and sends no further byte, but the classifier keeps filling the queue.
// min_length is written through the configuration channel, which is always ready,
// and should be changed only while the block is idle.
module utf8_printable_run_extractor_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	input  logic                          end_of_stream,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [upre_pkg::MINLEN_W-1:0] min_length
);

	logic [upre_pkg::MINLEN_W-1:0] min_length_q;
	logic                          push;
	upre_pkg::cmd_t                push_cmd;
	upre_pkg::cmd_t                head;
	logic                          pop;
	logic                          q_full;
	logic                          q_empty;

	assign cfg_ready = 1'b1;
	assign in_stall = q_full;

	// Minimum run length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= upre_pkg::MINLEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			min_length_q <= min_length;
		end
	end

	upre_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_byte      (in_byte),
		.end_of_stream(end_of_stream),
		.q_full       (q_full),
		.push         (push),
		.cmd          (push_cmd)
	);

	upre_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.full    (q_full),
		.empty   (q_empty)
	);

	upre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.min_length(min_length_q),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

// ===== design/upre_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module upre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/upre_front.sv =====
// Byte classifier: tracks UTF-8 sequences and turns input words into run commands.
module upre_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [7:0]            in_byte,
	input  logic                  end_of_stream,
	input  logic                  q_full,
	output logic                  push,
	output upre_pkg::cmd_t        cmd
);

	logic [1:0]      cont_q, cont_d;
	logic [1:0]      seq_len_q, seq_len_d;
	logic [3:0][7:0] seq_q, seq_d;
	logic            accept;
	logic            is_print;
	logic [1:0]      need;
	logic [3:0][7:0] seq_ins;
	logic [7:0]      second;
	logic            bad;
	logic            push_d;

	assign accept = in_valid && !q_full;

	// Printable ASCII, newline, and lead byte classes.
	always_comb begin
		is_print = ((in_byte >= 8'h20) && (in_byte <= 8'h7E)) || (in_byte == upre_pkg::NEWLINE);
		if ((in_byte >= 8'hC2) && (in_byte <= 8'hDF)) begin
			need = 2'd1;
		end else if ((in_byte >= 8'hE1) && (in_byte <= 8'hEF)) begin
			need = 2'd2;
		end else if ((in_byte >= 8'hF1) && (in_byte <= 8'hF4)) begin
			need = 2'd3;
		end else begin
			need = 2'd0;
		end
	end

	// Sequence with the current byte placed as the next continuation.
	always_comb begin
		seq_ins = seq_q;
		seq_ins[seq_len_q] = in_byte;
		second = seq_ins[1];
		bad = ((seq_ins[0] == 8'hED) && (second >= 8'hA0)) ||
		      ((seq_ins[0] == 8'hF4) && (second >= 8'h90));
	end

	// Next sequence state and the command produced by this word.
	always_comb begin
		cont_d = cont_q;
		seq_len_d = seq_len_q;
		seq_d = seq_q;
		push_d = 1'b0;
		cmd.kind = upre_pkg::CMD_END;
		cmd.restart = 1'b0;
		cmd.len_m1 = 2'd0;
		cmd.bytes = {4{in_byte}};
		if (end_of_stream) begin
			cont_d = 2'd0;
			seq_len_d = 2'd0;
			push_d = 1'b1;
			cmd.kind = upre_pkg::CMD_EOS;
		end else if (cont_q != 2'd0) begin
			if (in_byte[7:6] != 2'b10) begin
				// Broken sequence: the run ends and a printable or lead byte starts afresh.
				cont_d = 2'd0;
				seq_len_d = 2'd0;
				push_d = 1'b1;
				if (is_print) begin
					cmd.kind = upre_pkg::CMD_CHAR;
					cmd.restart = 1'b1;
				end else if (need != 2'd0) begin
					seq_d[0] = in_byte;
					seq_len_d = 2'd1;
					cont_d = need;
				end
			end else begin
				seq_d = seq_ins;
				seq_len_d = seq_len_q + 2'd1;
				cont_d = cont_q - 2'd1;
				if (cont_q == 2'd1) begin
					seq_len_d = 2'd0;
					push_d = 1'b1;
					if (!bad) begin
						cmd.kind = upre_pkg::CMD_CHAR;
						cmd.len_m1 = seq_len_q;
						cmd.bytes = seq_ins;
					end
				end
			end
		end else if (is_print) begin
			push_d = 1'b1;
			cmd.kind = upre_pkg::CMD_CHAR;
		end else if (need != 2'd0) begin
			seq_d[0] = in_byte;
			seq_len_d = 2'd1;
			cont_d = need;
		end else begin
			push_d = 1'b1;
		end
	end

	assign push = accept && push_d;

	// Sequence control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_q <= 2'd0;
			seq_len_q <= 2'd0;
		end else if (accept) begin
			cont_q <= cont_d;
			seq_len_q <= seq_len_d;
		end
	end

	// Collected sequence bytes.
	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q <= seq_d;
		end
	end

endmodule

// ===== design/upre_queue.sv =====
// Short command queue that decouples the classifier from the run engine.
module upre_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  upre_pkg::cmd_t push_cmd,
	input  logic           pop,
	output upre_pkg::cmd_t head,
	output logic           full,
	output logic           empty
);

	upre_pkg::cmd_t                    entries_q [upre_pkg::QUEUE_DEPTH];
	logic [upre_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [upre_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [upre_pkg::QCNT_W-1:0]       count_q;

	assign full = (count_q == upre_pkg::QCNT_W'(upre_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = entries_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + upre_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + upre_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + upre_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - upre_pkg::QCNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== design/upre_back.sv =====
// Run engine: counts characters, holds run bytes, and emits qualified runs.
module upre_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [upre_pkg::MINLEN_W-1:0]  min_length,
	input  upre_pkg::cmd_t                 head,
	input  logic                           empty,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     out_byte,
	output logic                           last
);

	upre_pkg::back_state_t state_q, state_d;
	upre_pkg::cmd_t        cmd_q, cmd_d;
	logic [1:0]                    k_q, k_d;
	logic [upre_pkg::CHAR_W-1:0]   chars_q, chars_d, base_chars;
	logic [upre_pkg::BUF_CW-1:0]   buffered_q, buffered_d;
	logic [upre_pkg::BUF_AW-1:0]   idx_q, idx_d;
	logic                          owed_q, owed_d;
	logic [upre_pkg::CHAR_W-1:0]   eff;
	logic                          out_free;
	logic                          out_load;
	logic [7:0]                    out_data;
	logic                          out_last;
	logic                          wr_en;
	logic [7:0]                    rd_data;
	logic                          flush_end;
	logic                          out_valid_q;
	logic [7:0]                    out_byte_q;
	logic                          last_q;

	assign eff = upre_pkg::effective_min(min_length);
	assign out_free = !out_valid_q || !out_stall;
	assign flush_end = ((upre_pkg::BUF_CW'(idx_q) + upre_pkg::BUF_CW'(1)) == buffered_q);
	assign base_chars = head.restart ? '0 : chars_q;

	// Held run bytes.
	upre_ram #(
		.WIDTH(8),
		.DEPTH(upre_pkg::RUN_DEPTH)
	) u_run_buf (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(buffered_q[upre_pkg::BUF_AW-1:0]),
		.wr_data(cmd_q.bytes[k_q]),
		.rd_addr(idx_d),
		.rd_data(rd_data)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			upre_pkg::BK_IDLE: begin
				if (!empty && out_free && (head.kind == upre_pkg::CMD_CHAR)) begin
					state_d = upre_pkg::BK_WRITE;
				end
			end
			upre_pkg::BK_WRITE: begin
				if (k_q == cmd_q.len_m1) begin
					state_d = upre_pkg::BK_DECIDE;
				end
			end
			upre_pkg::BK_DECIDE: begin
				if ((chars_q == eff) && owed_q) begin
					state_d = upre_pkg::BK_NL;
				end else if (chars_q >= eff) begin
					state_d = upre_pkg::BK_FLUSH;
				end else begin
					state_d = upre_pkg::BK_IDLE;
				end
			end
			upre_pkg::BK_NL: begin
				if (out_free) begin
					state_d = upre_pkg::BK_FLUSH;
				end
			end
			upre_pkg::BK_FLUSH: begin
				if (out_free && flush_end) begin
					state_d = upre_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = upre_pkg::BK_IDLE;
			end
		endcase
	end

	// Datapath controls and register updates for each state.
	always_comb begin
		pop = 1'b0;
		wr_en = 1'b0;
		out_load = 1'b0;
		out_data = upre_pkg::NEWLINE;
		out_last = 1'b0;
		cmd_d = cmd_q;
		k_d = k_q;
		chars_d = chars_q;
		buffered_d = buffered_q;
		idx_d = idx_q;
		owed_d = owed_q;
		unique case (state_q)
			upre_pkg::BK_IDLE: begin
				if (!empty && out_free) begin
					pop = 1'b1;
					unique case (head.kind)
						upre_pkg::CMD_CHAR: begin
							cmd_d = head;
							k_d = 2'd0;
							chars_d = (base_chars <= eff) ? base_chars + upre_pkg::CHAR_W'(1)
							                              : base_chars;
							buffered_d = head.restart ? '0 : buffered_q;
						end
						upre_pkg::CMD_EOS: begin
							chars_d = '0;
							buffered_d = '0;
							owed_d = 1'b0;
							out_load = owed_q;
							out_last = 1'b1;
						end
						default: begin
							chars_d = '0;
							buffered_d = '0;
						end
					endcase
				end
			end
			upre_pkg::BK_WRITE: begin
				k_d = k_q + 2'd1;
				if (buffered_q < upre_pkg::BUF_CW'(upre_pkg::RUN_DEPTH)) begin
					wr_en = 1'b1;
					buffered_d = buffered_q + upre_pkg::BUF_CW'(1);
				end
			end
			upre_pkg::BK_DECIDE: begin
				// Gap cycle so the first buffer read sees the last write.
			end
			upre_pkg::BK_NL: begin
				out_load = out_free;
			end
			upre_pkg::BK_FLUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					out_data = rd_data;
					out_last = flush_end;
					if (flush_end) begin
						idx_d = '0;
						buffered_d = '0;
						owed_d = (rd_data != upre_pkg::NEWLINE);
					end else begin
						idx_d = idx_q + upre_pkg::BUF_AW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= upre_pkg::BK_IDLE;
			chars_q <= '0;
			buffered_q <= '0;
			idx_q <= '0;
			owed_q <= 1'b0;
			k_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			chars_q <= chars_d;
			buffered_q <= buffered_d;
			idx_q <= idx_d;
			owed_q <= owed_d;
			k_q <= k_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Current command and output word.
	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		if (out_load) begin
			out_byte_q <= out_data;
			last_q <= out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign last = last_q;

endmodule
